// File: sv/ilid_pkg.sv
// Package for the indexed list insert/delete unit.
// Holds field widths, action and status codes, and the command broadcast to the cells.
// No dependencies.
`timescale 1ns / 1ps

package ilid_pkg;

  localparam int VAL_W     = 32;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;
  localparam int CNT_MAX   = 31;
  localparam int DEPTH_DEF = 16;
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_EDIT   = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2
  } status_e;

  // What every cell does in the cycle an item is taken.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [CNT_W-1:0]        pos;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

// File: sv/ilid_cell.sv
// One storage cell of the list chain.
// Depends on ilid_pkg for the command struct; trades data with its neighbors.
`timescale 1ns / 1ps

module ilid_cell
  import ilid_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] data_o
);

  localparam logic [CNT_W-1:0] PosC = CNT_W'(POS);

  logic signed [VAL_W-1:0] data_q, data_d;
  logic [CNT_W:0]          pos_next;

  assign pos_next = {1'b0, PosC} + (CNT_W+1)'(1);

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      OP_WRITE: begin
        if (cmd_i.pos == PosC) data_d = cmd_i.value;
      end
      OP_INSERT: begin
        // Cells from the insert point up to the old count move up by one.
        if (cmd_i.pos == PosC) begin
          data_d = cmd_i.value;
        end else if (PosC > cmd_i.pos && PosC <= cmd_i.count) begin
          data_d = left_i;
        end
      end
      OP_DELETE: begin
        if (PosC >= cmd_i.pos && pos_next < {1'b0, cmd_i.count}) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: sv/indexed_list_insert_delete_unit.sv
// Indexed list insert/delete unit: top level with the control, count and result register.
// Depends on ilid_pkg and instantiates a row of ilid_cell.
`timescale 1ns / 1ps

// The list lives in a row of register cells; insert and delete move every affected
// entry by one place as the item is taken, and the block
// accepts one item per clock. The input stalls only while a result sits in the output
// register and the output side stalls it. Capacity writes are registered and are
// clamped to the range one through the built depth, at most 31.
module indexed_list_insert_delete_unit
  import ilid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     capacity_we_i,
  input  logic [CNT_W-1:0]         capacity_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic [IDX_W-1:0]         index_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [VAL_W-1:0]  read_value_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     is_empty_o,
  output logic                     is_full_o
);

  // The count field cannot exceed its width, so deeper builds keep 32 cells and a capacity of 31.
  localparam int NCELL  = (DEPTH < CNT_MAX + 1) ? DEPTH : CNT_MAX + 1;
  localparam int CAPMAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
  localparam logic [CNT_W-1:0] CapMaxC = CNT_W'(CAPMAX);

  logic [CNT_W-1:0]        cap_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  logic [STAT_W-1:0]       status_q;
  logic signed [VAL_W-1:0] rd_q;
  logic [CNT_W-1:0]        out_count_q;
  logic                    empty_q, full_q;

  logic                    in_acc;
  logic [CNT_W-1:0]        eff_cap;
  logic                    list_full;
  logic [CNT_W-1:0]        idx;
  status_e                 status;
  logic signed [VAL_W-1:0] rd_val;
  logic signed [VAL_W-1:0] cell_rd;
  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cell_data [NCELL];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx        = {1'b0, index_i};

  always_comb begin
    eff_cap = cap_q;
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_q > CapMaxC) begin
      eff_cap = CapMaxC;
    end
  end

  assign list_full = count_q >= eff_cap;

  // Read port: select the addressed cell.
  always_comb begin
    cell_rd = '0;
    for (int i = 0; i < NCELL; i++) begin
      if (idx == CNT_W'(i)) cell_rd = cell_rd | cell_data[i];
    end
  end

  always_comb begin
    status    = ST_DONE;
    rd_val    = '0;
    count_d   = count_q;
    cmd.op    = OP_NONE;
    cmd.pos   = idx;
    cmd.count = count_q;
    cmd.value = value_i;
    if (in_acc) begin
      unique case (action_i)
        ACT_APPEND: begin
          if (list_full) begin
            status = ST_FULL;
          end else begin
            cmd.op  = OP_WRITE;
            cmd.pos = count_q;
            count_d = count_q + CNT_W'(1);
          end
        end
        ACT_INSERT: begin
          priority if (list_full) begin
            status = ST_FULL;
          end else if (idx > count_q) begin
            status = ST_BADIDX;
          end else begin
            cmd.op  = OP_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
        ACT_EDIT: begin
          if (idx >= count_q) status = ST_BADIDX;
          else cmd.op = OP_WRITE;
        end
        ACT_DELETE: begin
          if (idx >= count_q) begin
            status = ST_BADIDX;
          end else begin
            cmd.op  = OP_DELETE;
            count_d = count_q - CNT_W'(1);
          end
        end
        ACT_READ: begin
          if (idx >= count_q) begin
            status = ST_BADIDX;
            rd_val = -32'sd1;
          end else begin
            rd_val = cell_rd;
          end
        end
        default: status = ST_DONE;
      endcase
    end
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic signed [VAL_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == NCELL - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    ilid_cell #(.POS(g)) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (capacity_we_i) cap_q <= capacity_i;
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q    <= status;
      rd_q        <= rd_val;
      out_count_q <= count_d;
      empty_q     <= (count_d == '0);
      full_q      <= (count_d >= eff_cap);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = rd_q;
  assign count_o      = out_count_q;
  assign is_empty_o   = empty_q;
  assign is_full_o    = full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapMaxC)
    else $error("entry count exceeds the cell row");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1)
              || count_q == $past(count_q) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_FULL) |-> full_q)
    else $error("full status without full flag");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (empty_q == (out_count_q == '0)))
    else $error("empty flag disagrees with count");

endmodule
